// ===== rtl/core/ilcs_pkg.sv =====
// ----------------------------------------------------------------------------
// ilcs_pkg
// Shared types, constants and ones' complement helpers for the IPv4 / L4
// checksum stream block.
// ----------------------------------------------------------------------------
package ilcs_pkg;

	// Queue between the classifier and the summing back end
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;

	// Fixed header word positions and the saturation limit of the word index
	localparam logic [15:0] IDX_VER_IHL  = 16'd0;
	localparam logic [15:0] IDX_TOT_LEN  = 16'd1;
	localparam logic [15:0] IDX_PROTO    = 16'd4;
	localparam logic [15:0] IDX_HDR_CHK  = 16'd5;
	localparam logic [15:0] IDX_ADDR_LO  = 16'd6;
	localparam logic [15:0] IDX_ADDR_HI  = 16'd9;
	localparam logic [15:0] IDX_SAT      = 16'hffff;

	// IP protocol numbers
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP  = 8'd6;
	localparam logic [7:0] PROTO_UDP  = 8'd17;

	// Checksum word offsets inside the L4 header
	localparam logic [15:0] OFF_ICMP_CHK = 16'd1;
	localparam logic [15:0] OFF_TCP_CHK  = 16'd8;
	localparam logic [15:0] OFF_UDP_CHK  = 16'd3;

	// Result kind codes
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_ICMP = 2'd1;
	localparam logic [1:0] KIND_TCP  = 2'd2;
	localparam logic [1:0] KIND_UDP  = 2'd3;

	// One classified beat, as queued for the back end
	typedef struct packed {
		logic [15:0] word;     // packet word as received
		logic        pad;      // odd tail byte: drop the low byte from the payload sum
		logic        add_hdr;  // feeds the IP header sum
		logic        add_pay;  // feeds the L4 payload sum
		logic        add_psd;  // feeds the address part of the pseudo-header
		logic        last;     // closes the packet
		logic [1:0]  kind;     // L4 kind, valid on last
		logic        trunc;    // packet shorter than its length field, valid on last
		logic [15:0] tot_len;  // total length, valid on last
		logic [15:0] hlen_c;   // complement of header length in bytes, valid on last
		logic [7:0]  proto;    // protocol byte, valid on last
	} ilcs_item_t;

	// Two-operand ones' complement add with end-around carry
	function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

	// Fold a 19-bit plain sum into a 16-bit ones' complement value
	function automatic logic [15:0] oc_fold19(input logic [18:0] s);
		logic [16:0] f;
		f = {1'b0, s[15:0]} + {14'd0, s[18:16]};
		return f[15:0] + {15'd0, f[16]};
	endfunction

endpackage

// ===== rtl/core/ilcs_front.sv =====
// ----------------------------------------------------------------------------
// ilcs_front
// Tracks the word position, captures the header fields and tags each beat
// with the sums it belongs to before it enters the queue.
// ----------------------------------------------------------------------------
module ilcs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [15:0]          data_word,
	input  logic                 last,
	input  logic                 q_full,
	output logic                 q_push,
	output ilcs_pkg::ilcs_item_t q_item
);

	logic [15:0] word_index_q;
	logic [4:0]  header_words_q;
	logic [15:0] total_length_q;
	logic [7:0]  protocol_q;

	logic [4:0]  hw_eff;
	logic [15:0] tl_eff;
	logic [7:0]  pr_eff;
	logic [16:0] two_i;
	logic [17:0] two_i_p1;
	logic [17:0] two_i_p2;
	logic [15:0] off;
	logic        in_pay;
	logic        is_chk;
	logic        pad;
	logic [1:0]  kind;
	logic [5:0]  hlen_bytes;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;

	// Take header fields from the current beat when it carries them
	always_comb begin
		hw_eff = (word_index_q == ilcs_pkg::IDX_VER_IHL) ? {data_word[11:8], 1'b0}
			: header_words_q;
		tl_eff = (word_index_q == ilcs_pkg::IDX_TOT_LEN) ? data_word : total_length_q;
		pr_eff = (word_index_q == ilcs_pkg::IDX_PROTO) ? data_word[7:0] : protocol_q;
	end

	// Classify the beat
	always_comb begin
		two_i      = {word_index_q, 1'b0};
		two_i_p1   = {1'b0, two_i} + 18'd1;
		two_i_p2   = {1'b0, two_i} + 18'd2;
		off        = word_index_q - {11'd0, hw_eff};
		in_pay     = (word_index_q >= {11'd0, hw_eff}) && (two_i < {1'b0, tl_eff});
		is_chk     = ((pr_eff == ilcs_pkg::PROTO_ICMP) && (off == ilcs_pkg::OFF_ICMP_CHK))
			|| ((pr_eff == ilcs_pkg::PROTO_TCP) && (off == ilcs_pkg::OFF_TCP_CHK))
			|| ((pr_eff == ilcs_pkg::PROTO_UDP) && (off == ilcs_pkg::OFF_UDP_CHK));
		pad        = two_i_p1 >= {2'd0, tl_eff};
		hlen_bytes = {hw_eff, 1'b0};
		case (pr_eff)
			ilcs_pkg::PROTO_ICMP: kind = ilcs_pkg::KIND_ICMP;
			ilcs_pkg::PROTO_TCP:  kind = ilcs_pkg::KIND_TCP;
			ilcs_pkg::PROTO_UDP:  kind = ilcs_pkg::KIND_UDP;
			default:              kind = ilcs_pkg::KIND_NONE;
		endcase

		q_item.word    = data_word;
		q_item.pad     = pad;
		q_item.add_hdr = ({11'd0, hw_eff} > word_index_q)
			&& (word_index_q != ilcs_pkg::IDX_HDR_CHK);
		q_item.add_pay = in_pay && !is_chk;
		q_item.add_psd = (word_index_q >= ilcs_pkg::IDX_ADDR_LO)
			&& (word_index_q <= ilcs_pkg::IDX_ADDR_HI);
		q_item.last    = last;
		q_item.kind    = kind;
		q_item.trunc   = two_i_p2 < {2'd0, tl_eff};
		q_item.tot_len = tl_eff;
		q_item.hlen_c  = ~{10'd0, hlen_bytes};
		q_item.proto   = pr_eff;
	end

	// Advance the position and hold the header fields; clear on the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q   <= '0;
			header_words_q <= '0;
			total_length_q <= '0;
			protocol_q     <= '0;
		end else if (q_push) begin
			if (last) begin
				word_index_q   <= '0;
				header_words_q <= '0;
				total_length_q <= '0;
				protocol_q     <= '0;
			end else begin
				if (word_index_q != ilcs_pkg::IDX_SAT) begin
					word_index_q <= word_index_q + 16'd1;
				end
				header_words_q <= hw_eff;
				total_length_q <= tl_eff;
				protocol_q     <= pr_eff;
			end
		end
	end

endmodule

// ===== rtl/core/ilcs_fifo.sv =====
// ----------------------------------------------------------------------------
// ilcs_fifo
// Short queue of classified beats between the front and back ends.
// ----------------------------------------------------------------------------
module ilcs_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ilcs_pkg::ilcs_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 nonempty,
	output ilcs_pkg::ilcs_item_t pop_item
);

	ilcs_pkg::ilcs_item_t             entry_q [ilcs_pkg::FIFO_DEPTH];
	logic [ilcs_pkg::FIFO_AW-1:0]     wr_ptr_q;
	logic [ilcs_pkg::FIFO_AW-1:0]     rd_ptr_q;
	logic [ilcs_pkg::FIFO_AW:0]       count_q;

	assign full     = count_q == (ilcs_pkg::FIFO_AW+1)'(ilcs_pkg::FIFO_DEPTH);
	assign nonempty = count_q != '0;
	assign pop_item = entry_q[rd_ptr_q];

	// Store the incoming beat
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/ilcs_back.sv =====
// ----------------------------------------------------------------------------
// ilcs_back
// Runs the ones' complement sums over queued beats, closes each packet into
// a finishing stage and holds the result in the output register.
// ----------------------------------------------------------------------------
module ilcs_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_nonempty,
	input  ilcs_pkg::ilcs_item_t q_item,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [15:0]          ip_checksum,
	output logic [15:0]          l4_checksum,
	output logic [1:0]           l4_kind,
	output logic                 truncated
);

	logic [15:0] hdr_sum_q;
	logic [15:0] pay_sum_q;
	logic [15:0] psd_sum_q;
	logic [15:0] hdr_next;
	logic [15:0] pay_next;
	logic [15:0] psd_next;
	logic [15:0] pay_word;

	logic        valid_s1;
	logic [15:0] hdr_s1;
	logic [15:0] pay_s1;
	logic [15:0] psd_s1;
	logic [15:0] tot_len_s1;
	logic [15:0] hlen_c_s1;
	logic [7:0]  proto_s1;
	logic [1:0]  kind_s1;
	logic        trunc_s1;

	logic        out_valid_q;
	logic [15:0] ip_chk_q;
	logic [15:0] l4_chk_q;
	logic [1:0]  kind_q;
	logic        trunc_q;

	logic        out_load;
	logic        s1_ready;
	logic [18:0] full_sum;
	logic [15:0] l4_value;

	assign out_load = valid_s1 && (!out_valid_q || out_ready);
	assign s1_ready = !valid_s1 || out_load;
	assign q_pop    = q_nonempty && (!q_item.last || s1_ready);

	// Accumulate the current beat; mask the odd tail byte for the payload only
	always_comb begin
		pay_word = q_item.pad ? {q_item.word[15:8], 8'h00} : q_item.word;
		hdr_next = q_item.add_hdr ? ilcs_pkg::oc_add(hdr_sum_q, q_item.word) : hdr_sum_q;
		pay_next = q_item.add_pay ? ilcs_pkg::oc_add(pay_sum_q, pay_word) : pay_sum_q;
		psd_next = q_item.add_psd ? ilcs_pkg::oc_add(psd_sum_q, q_item.word) : psd_sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_sum_q <= '0;
			pay_sum_q <= '0;
			psd_sum_q <= '0;
		end else if (q_pop) begin
			if (q_item.last) begin
				hdr_sum_q <= '0;
				pay_sum_q <= '0;
				psd_sum_q <= '0;
			end else begin
				hdr_sum_q <= hdr_next;
				pay_sum_q <= pay_next;
				psd_sum_q <= psd_next;
			end
		end
	end

	// Capture the closed packet into the finishing stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_ready) begin
			valid_s1 <= q_pop && q_item.last;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			hdr_s1     <= hdr_next;
			pay_s1     <= pay_next;
			psd_s1     <= psd_next;
			tot_len_s1 <= q_item.tot_len;
			hlen_c_s1  <= q_item.hlen_c;
			proto_s1   <= q_item.proto;
			kind_s1    <= q_item.kind;
			trunc_s1   <= q_item.trunc;
		end
	end

	// Add the pseudo-header terms and invert for TCP/UDP; ICMP inverts the payload sum, others give zero
	always_comb begin
		full_sum = {3'd0, pay_s1} + {3'd0, tot_len_s1} + {3'd0, hlen_c_s1}
			+ {11'd0, proto_s1} + {3'd0, psd_s1};
		case (kind_s1)
			ilcs_pkg::KIND_ICMP: l4_value = ~pay_s1;
			ilcs_pkg::KIND_TCP,
			ilcs_pkg::KIND_UDP:  l4_value = ~ilcs_pkg::oc_fold19(full_sum);
			default:             l4_value = '0;
		endcase
	end

	// Hold the result until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ip_chk_q <= ~hdr_s1;
			l4_chk_q <= l4_value;
			kind_q   <= kind_s1;
			trunc_q  <= trunc_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign ip_checksum = ip_chk_q;
	assign l4_checksum = l4_chk_q;
	assign l4_kind     = kind_q;
	assign truncated   = trunc_q;

endmodule

// ===== rtl/core/ipv4_l4_checksum_stream_top.sv =====
// ----------------------------------------------------------------------------
// ipv4_l4_checksum_stream_top
// IPv4 header and ICMP/TCP/UDP checksum over a stream of 16-bit words.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+----------------------------------
//  in       | input     | in_valid / in_ready | data_word, last
//  out      | output    | out_valid/out_ready | ip_checksum, l4_checksum,
//           |           |                     | l4_kind, truncated
//
//  One word is taken every cycle while the four-entry beat queue has room.
//  After the last word is taken it passes through the beat queue; its pop closes
//  the packet into the finishing stage, and the pseudo-header add feeds the
//  output register.
//  in_ready depends only on queue occupancy; a stalled output fills the queue.
//  Reset (arst_n low) clears position, sums, queue and result valid.
// ----------------------------------------------------------------------------
module ipv4_l4_checksum_stream_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] data_word,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] ip_checksum,
	output logic [15:0] l4_checksum,
	output logic [1:0]  l4_kind,
	output logic        truncated
);

	ilcs_pkg::ilcs_item_t push_item;
	ilcs_pkg::ilcs_item_t pop_item;
	logic                 push;
	logic                 pop;
	logic                 full;
	logic                 nonempty;

	ilcs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_word (data_word),
		.last      (last),
		.q_full    (full),
		.q_push    (push),
		.q_item    (push_item)
	);

	ilcs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.nonempty  (nonempty),
		.pop_item  (pop_item)
	);

	ilcs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_nonempty  (nonempty),
		.q_item      (pop_item),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ip_checksum (ip_checksum),
		.l4_checksum (l4_checksum),
		.l4_kind     (l4_kind),
		.truncated   (truncated)
	);

endmodule

// ===== rtl/core/ilcs_checker.sv =====
// ----------------------------------------------------------------------------
// ilcs_checker
// Port-level checks for the checksum stream block, bound to the top level.
// ----------------------------------------------------------------------------
module ilcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] ip_checksum,
	input logic [15:0] l4_checksum,
	input logic [1:0]  l4_kind,
	input logic        truncated
);

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ip_checksum)
		&& $stable(l4_checksum) && $stable(l4_kind) && $stable(truncated))
		else $error("result beat changed while stalled");

	// No L4 checksum without a recognised protocol
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (l4_kind == ilcs_pkg::KIND_NONE) |-> l4_checksum == 16'd0)
		else $error("nonzero L4 checksum for unknown protocol");

	// Ready drops only after a beat has been taken
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("in_ready fell without an accepted beat");

endmodule

bind ipv4_l4_checksum_stream_top ilcs_checker u_ilcs_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.ip_checksum (ip_checksum),
	.l4_checksum (l4_checksum),
	.l4_kind     (l4_kind),
	.truncated   (truncated)
);
